// ===== hdl/ffsa_pkg.sv =====
// ffsa_pkg: types, constants and codes of the first-fit segment allocator
// used by every module under hdl
`default_nettype none
package ffsa_pkg;
  localparam int MEM_UNITS_DEF    = 1024;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int PID_BITS_DEF     = 8;
  localparam int CFG_W   = 11;
  localparam int SIZE_W  = 11;
  localparam int ADDR_W  = 10;
  localparam int PIDF_W  = 8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [PIDF_W-1:0] pid;
    logic [SIZE_W-1:0] alloc_size;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] start_address;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ALLOC_DONE, S_SHIFT, S_SPLIT,
    S_MARK, S_MERGE, S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init;      // reload one hole
    logic load_req;  // latch request
    logic clr_idx;   // index back to zero
    logic inc_idx;
    logic scan_step; // allocate scan compare
    logic take;      // exact fit in place
    logic shift_step;
    logic split;
    logic mark_step; // free: mark pid segments
    logic merge_step;
    logic merge_end;
    logic set_rsp;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic zero_size;
    logic idx_end;   // index reached count
    logic hit;       // current entry fits
    logic exact;
    logic full;
    logic shift_end; // shift index reached target
    logic found;
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/ffsa_ctrl.sv =====
// ffsa_ctrl: sequencer for allocate scan/shift and free mark/merge passes
// depends on ffsa_pkg
`default_nettype none
module ffsa_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_go,
  input  wire              cfg_go,
  input  wire              rsp_free,
  input  ffsa_pkg::sts_t   sts,
  output ffsa_pkg::cmd_t   cmd,
  output logic [1:0]       rsp_code,
  output logic             busy
);
  ffsa_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ffsa_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    rsp_code = ffsa_pkg::ST_OK;
    busy = (state != ffsa_pkg::S_IDLE);
    unique case (state)
      ffsa_pkg::S_IDLE: begin
        if (cfg_go) begin
          cmd.init = 1'b1;
        end else if (in_go) begin
          cmd.load_req = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next = ffsa_pkg::S_SCAN;
        end
      end
      ffsa_pkg::S_SCAN: begin
        if (sts.is_free) begin
          state_next = ffsa_pkg::S_MARK;
        end else if (sts.zero_size || sts.idx_end) begin
          rsp_code = ffsa_pkg::ST_NOFIT;
          cmd.set_rsp = 1'b1;
          state_next = ffsa_pkg::S_RESP;
        end else if (sts.hit) begin
          cmd.scan_step = 1'b1;
          if (sts.exact) begin
            cmd.take = 1'b1;
            state_next = ffsa_pkg::S_ALLOC_DONE;
          end else if (sts.full) begin
            rsp_code = ffsa_pkg::ST_FULL;
            cmd.set_rsp = 1'b1;
            state_next = ffsa_pkg::S_RESP;
          end else begin
            state_next = ffsa_pkg::S_SHIFT;
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      ffsa_pkg::S_SHIFT: begin
        if (sts.shift_end) state_next = ffsa_pkg::S_SPLIT;
        else cmd.shift_step = 1'b1;
      end
      ffsa_pkg::S_SPLIT: begin
        cmd.split = 1'b1;
        state_next = ffsa_pkg::S_ALLOC_DONE;
      end
      ffsa_pkg::S_ALLOC_DONE: begin
        cmd.set_rsp = 1'b1;
        state_next = ffsa_pkg::S_RESP;
      end
      ffsa_pkg::S_MARK: begin
        if (sts.idx_end) begin
          cmd.clr_idx = 1'b1;
          if (sts.found) begin
            state_next = ffsa_pkg::S_MERGE;
          end else begin
            rsp_code = ffsa_pkg::ST_NOTFOUND;
            cmd.set_rsp = 1'b1;
            state_next = ffsa_pkg::S_RESP;
          end
        end else begin
          cmd.mark_step = 1'b1;
          cmd.inc_idx = 1'b1;
        end
      end
      ffsa_pkg::S_MERGE: begin
        if (sts.idx_end) begin
          cmd.merge_end = 1'b1;
          cmd.set_rsp = 1'b1;
          state_next = ffsa_pkg::S_RESP;
        end else begin
          cmd.merge_step = 1'b1;
          cmd.inc_idx = 1'b1;
        end
      end
      ffsa_pkg::S_RESP: begin
        if (rsp_free) state_next = ffsa_pkg::S_IDLE;
      end
      default: state_next = ffsa_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/ffsa_dp.sv =====
// ffsa_dp: segment table registers, scan index, shift and merge datapath
// depends on ffsa_pkg
`default_nettype none
module ffsa_dp #(
  parameter int MEM_UNITS    = ffsa_pkg::MEM_UNITS_DEF,
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int PID_BITS     = ffsa_pkg::PID_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  [ffsa_pkg::CFG_W-1:0]  cfg_value,
  input  ffsa_pkg::req_t              req,
  input  ffsa_pkg::cmd_t              cmd,
  input  wire  [1:0]                  rsp_code,
  output ffsa_pkg::sts_t              sts,
  output ffsa_pkg::rsp_t              rsp
);
  localparam int UW = $clog2(MEM_UNITS + 1);
  localparam int IW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [UW-1:0]       start;
    logic [UW-1:0]       size;
    logic                hole;
    logic [PID_BITS-1:0] owner;
  } seg_t;

  seg_t          tbl [MAX_SEGMENTS];
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] wr;      // merge write pointer / shift pointer
  logic [IW-1:0] hit_i;
  logic          is_free;
  logic [PID_BITS-1:0] pid;
  logic [UW-1:0] size_r;
  logic          zero_r;
  logic          found;
  logic [UW-1:0] cfg_w;

  seg_t cur, prev, below;
  logic [IW-1:0] i_i, w_i, wm1_i, sh_i;
  logic [UW+1:0] msum;

  assign i_i   = idx[IW-1:0];
  assign w_i   = wr[IW-1:0];
  assign wm1_i = IW'(wr - CW'(1));
  assign sh_i  = IW'(wr - CW'(1));
  assign cur   = tbl[i_i];
  assign prev  = tbl[wm1_i];
  assign below = tbl[sh_i];
  assign msum  = (UW+2)'(prev.size) + (UW+2)'(cur.size);

  // clamp the size register
  always_comb begin
    if (cfg_value == '0) cfg_w = UW'(1);
    else if (32'(cfg_value) > 32'(MEM_UNITS)) cfg_w = UW'(MEM_UNITS);
    else cfg_w = UW'(cfg_value);
  end

  // status toward controller
  always_comb begin
    sts.is_free   = is_free;
    sts.zero_size = zero_r;
    sts.idx_end   = (idx >= count);
    sts.hit       = cur.hole && (cur.size >= size_r);
    sts.exact     = (cur.size == size_r);
    sts.full      = (count >= CW'(MAX_SEGMENTS));
    sts.shift_end = (wr == CW'(hit_i));
    sts.found     = found;
  end

  // table and control registers
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) tbl[k] <= '0;
      tbl[0].size <= rst ? UW'((MEM_UNITS < 1024) ? MEM_UNITS : 1024) : cfg_w;
      tbl[0].hole <= 1'b1;
      count <= CW'(1);
      idx <= '0;
      wr <= '0;
    end else begin
      if (cmd.load_req) begin
        is_free <= (req.cmd == ffsa_pkg::CMD_FREE);
        pid     <= PID_BITS'(req.pid);
        size_r  <= (32'(req.alloc_size) > 32'(MEM_UNITS)) ? UW'(MEM_UNITS)
                   : UW'(req.alloc_size);
        // zero or larger than memory never fits
        zero_r  <= (req.alloc_size == '0) ||
                   (32'(req.alloc_size) > 32'(MEM_UNITS));
        found   <= 1'b0;
        wr      <= count;
      end
      if (cmd.clr_idx) idx <= '0;
      if (cmd.inc_idx) idx <= idx + CW'(1);
      if (cmd.clr_idx && !cmd.load_req) wr <= '0;
      // remember hit and start shifting from the top
      if (cmd.scan_step) hit_i <= i_i;
      if (cmd.take) begin
        tbl[i_i].hole  <= 1'b0;
        tbl[i_i].owner <= pid;
        rsp.start_address <= ffsa_pkg::ADDR_W'(cur.start);
      end
      if (cmd.shift_step) begin
        tbl[w_i] <= below;
        wr <= wr - CW'(1);
      end
      if (cmd.split) begin
        tbl[hit_i].size  <= size_r;
        tbl[hit_i].hole  <= 1'b0;
        tbl[hit_i].owner <= pid;
        tbl[IW'(hit_i + IW'(1))].start <= tbl[hit_i].start + size_r;
        tbl[IW'(hit_i + IW'(1))].size  <= tbl[IW'(hit_i + IW'(1))].size - size_r;
        count <= count + CW'(1);
        rsp.start_address <= ffsa_pkg::ADDR_W'(tbl[hit_i].start);
      end
      if (cmd.mark_step && !cur.hole && cur.owner == pid) begin
        tbl[i_i].hole  <= 1'b1;
        tbl[i_i].owner <= '0;
        found <= 1'b1;
      end
      // compaction: coalesce holes while copying down
      if (cmd.merge_step) begin
        if (wr != '0 && cur.hole && prev.hole) begin
          tbl[wm1_i].size <= UW'(msum);
        end else begin
          tbl[w_i] <= cur;
          wr <= wr + CW'(1);
        end
      end
      if (cmd.merge_end) begin
        for (int k = 0; k < MAX_SEGMENTS; k++)
          if (CW'(k) >= wr) tbl[k] <= '0;
        count <= wr;
      end
      if (cmd.set_rsp) begin
        rsp.status <= rsp_code;
        if (rsp_code != ffsa_pkg::ST_OK || is_free) rsp.start_address <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/first_fit_segment_allocator.sv =====
// first_fit_segment_allocator: top level joining controller and datapath
// depends on ffsa_pkg, ffsa_ctrl, ffsa_dp
//
// Usage: requests arrive on in_valid/in_stall with an ffsa_pkg::req_t
// payload (allocate or free by pid); one result per request leaves on
// out_valid/out_stall as ffsa_pkg::rsp_t. The size register is written on
// cfg_valid/cfg_ready while idle and reloads the table to one hole.
// An allocate scans the entries from the first up to the first hole that fits;
// when that hole is larger, the entries above it are shifted up and the hole is
// split. A free runs a mark pass and then a merge pass over the entries, and
// skips the merge pass when no segment of the pid exists.
// The scan, shift and merge each move one table entry per cycle, so one
// request is in flight at a time. Reset gives a single hole of MEM_UNITS
// units, capped at 1024, and no pending result. A stalled result holds in
// its register, and no new request is taken until that result transfers.
`default_nettype none
module first_fit_segment_allocator #(
  parameter int MEM_UNITS    = ffsa_pkg::MEM_UNITS_DEF,
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int PID_BITS     = ffsa_pkg::PID_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  ffsa_pkg::req_t             in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output ffsa_pkg::rsp_t             out_data,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [ffsa_pkg::CFG_W-1:0]  cfg_data
);
  ffsa_pkg::cmd_t cmd;
  ffsa_pkg::sts_t sts;
  logic [1:0]     rsp_code;
  logic           busy;
  logic           in_go, cfg_go, rsp_free;

  assign in_stall  = busy || cfg_valid;
  assign cfg_ready = !busy;
  assign in_go     = in_valid && !in_stall;
  assign cfg_go    = cfg_valid && cfg_ready;
  assign rsp_free  = !out_stall;

  ffsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_go), .cfg_go(cfg_go), .rsp_free(rsp_free),
    .sts(sts), .cmd(cmd), .rsp_code(rsp_code), .busy(busy)
  );

  ffsa_dp #(
    .MEM_UNITS(MEM_UNITS), .MAX_SEGMENTS(MAX_SEGMENTS), .PID_BITS(PID_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_value(cfg_data), .req(in_data), .cmd(cmd),
    .rsp_code(rsp_code), .sts(sts), .rsp(out_data)
  );

  // result is shown while the controller waits in its response state
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.set_rsp) out_valid <= 1'b1;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken with result pending");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid) else $error("config open with result pending");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
endmodule
`default_nettype wire
